// ===== design/oaht_pkg.sv =====
`timescale 1ns / 1ps
package oaht_pkg;
	localparam int REQ_W = 2;
	localparam int STATUS_W = 3;
	localparam int SIZE_W = 4;
	localparam int START_W = 10;
	localparam int SLOT_OUT_W = 10;
	localparam int TOTAL_W = 11;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_INSERT_AT = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL = 3'd2,
		ST_VALUE_SET = 3'd3,
		ST_RANGE = 3'd4,
		ST_OCCUPIED = 3'd5
	} status_t;

	typedef struct packed {
		logic load;
		logic read;
		logic step;
		logic finish;
		status_t status;
		logic write_entry;
		logic write_value;
		logic clear_entry;
		logic inc_count;
		logic dec_count;
		logic report_value;
		logic report_slot;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic start_bad;
		logic full;
		logic used;
		logic key_match;
		logic value_zero;
		logic exhausted;
		logic out_busy;
	} sts_t;
endpackage

// ===== design/oaht_if.sv =====
`timescale 1ns / 1ps
interface oaht_req_if #(
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
);
	logic valid;
	logic ready;
	logic [oaht_pkg::REQ_W-1:0] req_type;
	logic [KEY_BITS-1:0] key;
	logic [VALUE_BITS-1:0] value;
	logic [oaht_pkg::START_W-1:0] start_slot;
	modport source (output valid, req_type, key, value, start_slot, input ready);
	modport sink (input valid, req_type, key, value, start_slot, output ready);
endinterface

interface oaht_rsp_if #(
	parameter int VALUE_BITS = 32
);
	logic valid;
	logic ready;
	logic [oaht_pkg::STATUS_W-1:0] status;
	logic [VALUE_BITS-1:0] found_value;
	logic [oaht_pkg::SLOT_OUT_W-1:0] slot;
	logic [oaht_pkg::TOTAL_W-1:0] entry_total;
	modport source (output valid, status, found_value, slot, entry_total, input ready);
	modport sink (input valid, status, found_value, slot, entry_total, output ready);
endinterface

// ===== design/oaht_ctrl.sv =====
`timescale 1ns / 1ps
module oaht_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input logic [oaht_pkg::REQ_W-1:0] req_type,
	input oaht_pkg::sts_t sts,
	output oaht_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_EVAL = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic [oaht_pkg::REQ_W-1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= oaht_pkg::REQ_LOOKUP;
		end else begin
			state_q <= state_d;
			if (req_valid && req_ready) begin
				op_q <= req_type;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE) && !sts.clearing;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.status = oaht_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && req_ready) begin
					cmd.load = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.out_busy) begin
					state_d = S_EVAL;
				end else if (sts.start_bad) begin
					cmd.finish = 1'b1;
					cmd.status = oaht_pkg::ST_RANGE;
				end else begin
					unique case (op_q)
						oaht_pkg::REQ_LOOKUP, oaht_pkg::REQ_REMOVE: begin
							if (!sts.used) begin
								cmd.finish = 1'b1;
								cmd.status = oaht_pkg::ST_NOT_FOUND;
							end else if (sts.key_match) begin
								cmd.finish = 1'b1;
								cmd.report_value = 1'b1;
								cmd.report_slot = 1'b1;
								if (op_q == oaht_pkg::REQ_REMOVE) begin
									cmd.clear_entry = 1'b1;
									cmd.dec_count = 1'b1;
								end
							end else if (sts.exhausted) begin
								cmd.finish = 1'b1;
								cmd.status = oaht_pkg::ST_NOT_FOUND;
							end else begin
								cmd.step = 1'b1;
							end
						end
						oaht_pkg::REQ_INSERT: begin
							if (sts.full) begin
								cmd.finish = 1'b1;
								cmd.status = oaht_pkg::ST_FULL;
							end else if (!sts.used) begin
								cmd.finish = 1'b1;
								cmd.report_slot = 1'b1;
								cmd.write_entry = 1'b1;
								cmd.inc_count = 1'b1;
							end else if (sts.key_match) begin
								cmd.finish = 1'b1;
								cmd.report_slot = 1'b1;
								if (sts.value_zero) begin
									cmd.write_value = 1'b1;
								end else begin
									cmd.status = oaht_pkg::ST_VALUE_SET;
								end
							end else if (sts.exhausted) begin
								cmd.finish = 1'b1;
								cmd.status = oaht_pkg::ST_FULL;
							end else begin
								cmd.step = 1'b1;
							end
						end
						default: begin
							cmd.finish = 1'b1;
							if (sts.full) begin
								cmd.status = oaht_pkg::ST_FULL;
							end else if (sts.used) begin
								cmd.status = oaht_pkg::ST_OCCUPIED;
								cmd.report_slot = 1'b1;
							end else begin
								cmd.report_slot = 1'b1;
								cmd.write_entry = 1'b1;
								cmd.inc_count = 1'b1;
							end
						end
					endcase
				end
				if (cmd.step) begin
					state_d = S_HOLD;
				end else if (cmd.finish) begin
					state_d = S_IDLE;
				end
			end
			S_HOLD: begin
				state_d = S_READ;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== design/oaht_datapath.sv =====
`timescale 1ns / 1ps
module oaht_datapath #(
	parameter int SLOTS = 1024,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [oaht_pkg::SIZE_W-1:0] cfg_wdata,
	input logic [KEY_BITS-1:0] in_key,
	input logic [VALUE_BITS-1:0] in_value,
	input logic [oaht_pkg::START_W-1:0] in_start,
	input oaht_pkg::cmd_t cmd,
	output oaht_pkg::sts_t sts,
	output logic out_valid,
	input logic out_ready,
	output logic [oaht_pkg::STATUS_W-1:0] out_status,
	output logic [VALUE_BITS-1:0] out_found,
	output logic [oaht_pkg::SLOT_OUT_W-1:0] out_slot,
	output logic [oaht_pkg::TOTAL_W-1:0] out_total
);
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int LG_MAX = IDX_W;

	logic [KEY_BITS-1:0] key_mem [SLOTS];
	logic [VALUE_BITS-1:0] val_mem [SLOTS];
	logic used_mem [SLOTS];

	logic [oaht_pkg::SIZE_W-1:0] size_log2_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [oaht_pkg::START_W-1:0] start_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic [2*CNT_W-1:0] sq_q;
	logic [CNT_W-1:0] count_q;
	logic [KEY_BITS-1:0] rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic rd_used_q;
	logic clearing_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic [CNT_W-1:0] cap;
	logic [IDX_W-1:0] mask;
	logic [IDX_W-1:0] next_idx;
	logic [oaht_pkg::TOTAL_W-1:0] total_next;
	logic [CNT_W-1:0] count_d;

	always_comb begin
		logic [oaht_pkg::SIZE_W-1:0] lg;
		lg = (size_log2_q == '0) ? oaht_pkg::SIZE_W'(1) : size_log2_q;
		if (lg >= oaht_pkg::SIZE_W'(LG_MAX)) begin
			cap = CNT_W'(SLOTS);
		end else begin
			cap = CNT_W'(1) << lg;
		end
		mask = IDX_W'(cap - CNT_W'(1));
	end

	assign next_idx = (idx_q + IDX_W'(sq_q)) & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= oaht_pkg::SIZE_W'(10);
		end else if (cfg_we) begin
			size_log2_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_key;
			value_q <= in_value;
			start_q <= in_start;
			idx_q <= IDX_W'(in_start);
			n_q <= CNT_W'(1);
		end else if (cmd.step) begin
			idx_q <= next_idx;
			n_q <= n_q + CNT_W'(1);
		end
		sq_q <= n_q * n_q;
		if (cmd.read) begin
			rd_key_q <= key_mem[idx_q];
			rd_val_q <= val_mem[idx_q];
			rd_used_q <= used_mem[idx_q];
		end
		if (cmd.write_entry) begin
			key_mem[idx_q] <= key_q;
		end
		if (cmd.write_entry || cmd.write_value) begin
			val_mem[idx_q] <= value_q;
		end
		if (clearing_q) begin
			used_mem[clr_idx_q] <= 1'b0;
		end else if (cmd.write_entry) begin
			used_mem[idx_q] <= 1'b1;
		end else if (cmd.clear_entry) begin
			used_mem[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q <= '0;
			count_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(SLOTS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			count_q <= count_d;
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.inc_count) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.dec_count && count_q != '0) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign total_next = oaht_pkg::TOTAL_W'(count_d);

	always_comb begin
		sts.clearing = clearing_q;
		sts.start_bad = ({{CNT_W{1'b0}}, start_q} >= {{oaht_pkg::START_W{1'b0}}, cap});
		sts.full = (count_q >= cap);
		sts.used = rd_used_q;
		sts.key_match = (rd_key_q == key_q);
		sts.value_zero = (rd_val_q == '0);
		sts.exhausted = (n_q >= cap) || (next_idx == IDX_W'(start_q));
		sts.out_busy = out_valid && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status <= cmd.status;
			out_found <= cmd.report_value ? rd_val_q : '0;
			out_slot <= cmd.report_slot ? oaht_pkg::SLOT_OUT_W'(idx_q) : '0;
			out_total <= total_next;
		end
	end
endmodule

// ===== design/open_address_hash_table_core.sv =====
`timescale 1ns / 1ps
// A request is accepted in S_IDLE; its slot is read in S_READ and compared in S_EVAL.
// Each further probe steps the index in S_EVAL, then passes through S_HOLD and S_READ again.
// One request is handled at a time: no new request is accepted until the last has finished,
// and a result still waiting at the output holds the probe loop until it is taken.
// Reset clears the entry count and the output valid at once; a clearing pass over all SLOTS
// entries empties the used map before the first request is accepted. size_log2 resets to 10.
module open_address_hash_table_core #(
	parameter int SLOTS = 1024,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [oaht_pkg::SIZE_W-1:0] cfg_wdata,
	oaht_req_if.sink req,
	oaht_rsp_if.source rsp
);
	oaht_pkg::cmd_t cmd;
	oaht_pkg::sts_t sts;

	oaht_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_type(req.req_type),
		.sts(sts),
		.cmd(cmd)
	);

	oaht_datapath #(
		.SLOTS(SLOTS),
		.KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_key(req.key),
		.in_value(req.value),
		.in_start(req.start_slot),
		.cmd(cmd),
		.sts(sts),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_status(rsp.status),
		.out_found(rsp.found_value),
		.out_slot(rsp.slot),
		.out_total(rsp.entry_total)
	);
endmodule
